FILE: rtl/wtwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtwm_pkg;

    localparam int CHAR_W      = 8;
    localparam int WEEKDAY_W   = 3;
    localparam int MINUTE_W    = 11;
    localparam int FIELD_W     = 13;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_W_UP  = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_W_LO  = 8'h77;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [WEEKDAY_W-1:0] DAY_MONDAY = 3'd1;
    localparam logic [WEEKDAY_W-1:0] DAY_FRIDAY = 3'd5;
    localparam logic [3:0]           DAY_DIGIT_MAX = 4'd6;

    localparam logic CFG_IDX_WEEKDAY = 1'b0;
    localparam logic CFG_IDX_MINUTE  = 1'b1;

    typedef enum logic [2:0] {
        CH_COMMA,
        CH_COLON,
        CH_STAR,
        CH_WEEK,
        CH_DIGIT,
        CH_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } token_t;

    typedef enum logic [2:0] {
        PH_DAY,
        PH_SEEK1,
        PH_START,
        PH_END,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [2:0]         cnt;
        logic               ok;
        logic [FIELD_W-1:0] start_min;
        logic [FIELD_W-1:0] end_min;
        logic               found;
        logic               err;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        phase:     PH_DAY,
        cnt:       3'd0,
        ok:        1'b1,
        start_min: '0,
        end_min:   '0,
        found:     1'b0,
        err:       1'b0
    };

    localparam logic [2:0] FIELD_DIGITS = 3'd4;

    function automatic logic [FIELD_W-1:0] digit_weight(input logic [1:0] pos);
        logic [FIELD_W-1:0] w;
        case (pos)
            2'd0:    w = FIELD_W'(600);
            2'd1:    w = FIELD_W'(60);
            2'd2:    w = FIELD_W'(10);
            default: w = FIELD_W'(1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wtwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wtwm_front
    import wtwm_pkg::*;
(
    input  wire logic              spec_valid,
    output logic                   spec_ready,
    input  wire logic [CHAR_W-1:0] spec_char,
    input  wire logic              last_char,
    input  wire logic              q_full,
    output logic                   q_push,
    output token_t                 q_token
);

    logic [CHAR_W-1:0] offset;

    assign offset     = spec_char - CHAR_ZERO;
    assign spec_ready = !q_full;
    assign q_push     = spec_valid && !q_full;

    always_comb
    begin
        q_token.last  = last_char;
        q_token.digit = offset[3:0];
        if (spec_char == CHAR_COMMA)
        begin
            q_token.cls = CH_COMMA;
        end
        else if (spec_char == CHAR_COLON)
        begin
            q_token.cls = CH_COLON;
        end
        else if (spec_char == CHAR_STAR)
        begin
            q_token.cls = CH_STAR;
        end
        else if (spec_char == CHAR_W_UP || spec_char == CHAR_W_LO)
        begin
            q_token.cls = CH_WEEK;
        end
        else if (spec_char >= CHAR_ZERO && spec_char <= CHAR_NINE)
        begin
            q_token.cls = CH_DIGIT;
        end
        else
        begin
            q_token.cls = CH_OTHER;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wtwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wtwm_queue
    import wtwm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  token_t    push_token,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output token_t    head_token
);

    token_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wtwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wtwm_back
    import wtwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  head_valid,
    input  token_t                     head_token,
    output logic                       pop,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic                       in_window,
    output logic                       spec_error
);

    logic [WEEKDAY_W-1:0] weekday_reg;
    logic [MINUTE_W-1:0]  minute_reg;
    parse_t               parse_reg;
    parse_t               parse_next;
    parse_t               stepped;
    parse_t               closed;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic                 in_window_reg;
    logic                 spec_error_reg;

    function automatic logic [FIELD_W-1:0] field_value(input parse_t s,
                                                       input logic [FIELD_W-1:0] acc);
        return (s.ok && s.cnt == FIELD_DIGITS) ? acc : '0;
    endfunction

    // end of an entry, by comma or by the final character
    function automatic parse_t finish(input parse_t s, input logic [MINUTE_W-1:0] m);
        parse_t             r;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] mm;
        logic               hit;
        r   = s;
        e   = field_value(s, s.end_min);
        mm  = FIELD_W'(m);
        hit = 1'b0;
        case (s.phase)
            PH_DAY, PH_SEEK1, PH_START:
            begin
                r.err   = 1'b1;
                r.phase = PH_DAY;
            end
            PH_END:
            begin
                if (e > s.start_min)
                begin
                    hit = (mm >= s.start_min) && (mm <= e);
                end
                else
                begin
                    hit = (mm >= s.start_min) || (mm <= e);
                end
                if (hit)
                begin
                    r.found = 1'b1;
                    r.phase = PH_DONE;
                end
                else
                begin
                    r.phase = PH_DAY;
                end
            end
            PH_SKIP:
            begin
                r.phase = PH_DAY;
            end
            default:
            begin
                r.phase = s.phase;
            end
        endcase
        return r;
    endfunction

    function automatic parse_t advance(input parse_t s, input token_t t,
                                       input logic [WEEKDAY_W-1:0] wd,
                                       input logic [MINUTE_W-1:0] m);
        parse_t             r;
        logic               hit;
        logic               take;
        logic               good;
        logic [FIELD_W-1:0] term;
        r    = s;
        hit  = 1'b0;
        take = (s.cnt < FIELD_DIGITS);
        good = s.ok && (t.cls == CH_DIGIT);
        term = FIELD_W'(t.digit) * digit_weight(s.cnt[1:0]);
        if (t.cls == CH_COMMA)
        begin
            r = finish(s, m);
        end
        else
        begin
            case (s.phase)
                PH_DAY:
                begin
                    case (t.cls)
                        CH_STAR:
                        begin
                            hit = 1'b1;
                        end
                        CH_WEEK:
                        begin
                            hit = (wd >= DAY_MONDAY) && (wd <= DAY_FRIDAY);
                        end
                        CH_DIGIT:
                        begin
                            if (t.digit <= DAY_DIGIT_MAX)
                            begin
                                hit = (t.digit[2:0] == wd);
                            end
                            else
                            begin
                                r.err   = 1'b1;
                                r.phase = PH_SKIP;
                            end
                        end
                        CH_COLON:
                        begin
                            r.phase = PH_SKIP;
                        end
                        default:
                        begin
                            r.err   = 1'b1;
                            r.phase = PH_SKIP;
                        end
                    endcase
                    if (hit)
                    begin
                        r.phase = PH_SEEK1;
                    end
                end
                PH_SEEK1:
                begin
                    if (t.cls == CH_COLON)
                    begin
                        r.phase     = PH_START;
                        r.cnt       = 3'd0;
                        r.ok        = 1'b1;
                        r.start_min = '0;
                    end
                end
                PH_START:
                begin
                    if (t.cls == CH_COLON)
                    begin
                        r.start_min = field_value(s, s.start_min);
                        r.cnt       = 3'd0;
                        r.ok        = 1'b1;
                        r.end_min   = '0;
                        r.phase     = PH_END;
                    end
                    else if (take)
                    begin
                        if (good)
                        begin
                            r.start_min = s.start_min + term;
                        end
                        else
                        begin
                            r.ok = 1'b0;
                        end
                        r.cnt = s.cnt + 1'b1;
                    end
                end
                PH_END:
                begin
                    if (take)
                    begin
                        if (good)
                        begin
                            r.end_min = s.end_min + term;
                        end
                        else
                        begin
                            r.ok = 1'b0;
                        end
                        r.cnt = s.cnt + 1'b1;
                    end
                end
                default:
                begin
                    r = s;
                end
            endcase
        end
        return r;
    endfunction

    assign result_valid = result_valid_reg;
    assign in_window    = in_window_reg;
    assign spec_error   = spec_error_reg;

    // a final character needs the output slot free or freeing
    assign pop = head_valid && (!head_token.last || !result_valid_reg || result_ready);

    always_comb
    begin
        stepped           = advance(parse_reg, head_token, weekday_reg, minute_reg);
        closed            = finish(stepped, minute_reg);
        parse_next        = parse_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (pop)
        begin
            if (head_token.last)
            begin
                parse_next        = PARSE_CLEAR;
                result_valid_next = 1'b1;
            end
            else
            begin
                parse_next = stepped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_token.last)
        begin
            in_window_reg  <= closed.found;
            spec_error_reg <= closed.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weekday_reg      <= '0;
            minute_reg       <= '0;
            parse_reg        <= PARSE_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            parse_reg        <= parse_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we && cfg_index == CFG_IDX_WEEKDAY)
            begin
                weekday_reg <= cfg_data[WEEKDAY_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_IDX_MINUTE)
            begin
                minute_reg <= cfg_data[MINUTE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/weekday_time_window_match.sv
// weekday and time-of-day window check over a streamed schedule text
//
// spec channel: one character per transfer (spec_char, last_char), with
// spec_valid / spec_ready. last_char marks the final character of a text.
// result channel: one result per text (in_window, spec_error), with
// result_valid / result_ready, presented from the clock edge at which the
// final character leaves the two-entry character queue.
// configuration: cfg_we writes cfg_data into register cfg_index (0 for
// current weekday, 1 current minute) at the clock edge; the user must
// write only while idle, as the block itself does not enforce it.
// throughput: one character per cycle while the queue is not full.
// result_valid rises as the final character is popped from the queue.
// receiver stall: the result register holds; characters keep flowing into
// the parser until the next final character, which waits in the queue;
// spec_ready drops once the queue holds two characters.
// reset: parser state cleared, queue empty, no result pending, weekday and
// minute registers zero.
`timescale 1ns / 1ps
`default_nettype none

module weekday_time_window_match
    import wtwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  spec_valid,
    output logic                       spec_ready,
    input  wire logic [CHAR_W-1:0]     spec_char,
    input  wire logic                  last_char,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic                       in_window,
    output logic                       spec_error
);

    logic   q_full;
    logic   q_push;
    token_t q_token;
    logic   q_pop;
    logic   head_valid;
    token_t head_token;

    wtwm_front u_front (
        .spec_valid (spec_valid),
        .spec_ready (spec_ready),
        .spec_char  (spec_char),
        .last_char  (last_char),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_token    (q_token)
    );

    wtwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (q_token),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    wtwm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head_token   (head_token),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .in_window    (in_window),
        .spec_error   (spec_error)
    );

endmodule

`default_nettype wire

FILE: rtl/wtwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wtwm_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic spec_valid,
    input wire logic spec_ready,
    input wire logic last_char,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire logic in_window,
    input wire logic spec_error
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(in_window)
                                          && $stable(spec_error))
    else $error("stalled result changed");

    // with no result pending the queue cannot be full
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> spec_ready)
    else $error("spec channel stalled with no result pending");

    // final character with a free result slot shows up once popped from the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        spec_valid && spec_ready && last_char && !result_valid |-> ##2 result_valid)
    else $error("result missing after final character");

    // a result only leaves through a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
    else $error("result dropped without a transfer");

endmodule

bind weekday_time_window_match wtwm_checker u_wtwm_checker (.*);

`default_nettype wire
